// ===== rtl/core/ddc_pkg.sv =====
// Shared types, constants and calendar functions for the date difference counter.
package ddc_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0] DAYS_28   = DAY_W'(28);
  localparam logic [DAY_W-1:0] DAYS_29   = DAY_W'(29);
  localparam logic [DAY_W-1:0] DAYS_30   = DAY_W'(30);
  localparam logic [DAY_W-1:0] DAYS_31   = DAY_W'(31);

  // Reciprocal of 100 scaled by 2^21; exact quotient for every 14-bit year.
  localparam int unsigned RECIP_W     = 15;
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned CENT_Q_W    = YEAR_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(20972);

  typedef struct packed {
    logic load;
    logic fix;
    logic order;
    logic step;
  } ddc_cmd_t;

  typedef struct packed {
    logic equal;
    logic last;
  } ddc_status_t;

  // Gregorian leap rule: divisible by 400, or by 4 but not by 100.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W+RECIP_W-1:0] prod;
    logic [CENT_Q_W-1:0]       q;
    logic [YEAR_W-1:0]         q100;
    logic                      cent;
    prod = YEAR_W'(y) * RECIP_100;
    q    = prod[RECIP_SHIFT +: CENT_Q_W];
    // q * 100 as 64q + 32q + 4q.
    q100 = YEAR_W'({q, 6'b0}) + YEAR_W'({q, 5'b0}) + YEAR_W'({q, 2'b0});
    cent = (q100 == y);
    // A century year is divisible by 400 exactly when it is also divisible by 16.
    return (y[1:0] == 2'b00) && (!cent || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_FEB: len = leap ? DAYS_29 : DAYS_28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
      default: len = DAYS_31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/ddc_ctrl.sv =====
// Controller state machine for the date difference counter.
module ddc_ctrl
  import ddc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  ddc_status_t status_i,
  output ddc_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        done_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FIX   = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_ORDER;
      end
      ST_ORDER: begin
        cmd_o.order = 1'b1;
        if (status_i.equal) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/core/ddc_datapath.sv =====
// Datapath for the date difference counter: date correction, ordering and the day walk.
module ddc_datapath
  import ddc_pkg::*;
(
  input  logic               clk_i,
  input  ddc_cmd_t           cmd_i,
  input  logic [YEAR_W-1:0]  year_a_i,
  input  logic [MONTH_W-1:0] month_a_i,
  input  logic [DAY_W-1:0]   day_a_i,
  input  logic [YEAR_W-1:0]  year_b_i,
  input  logic [MONTH_W-1:0] month_b_i,
  input  logic [DAY_W-1:0]   day_b_i,
  output ddc_status_t        status_o,
  output logic [COUNT_W-1:0] day_count_o
);

  logic [YEAR_W-1:0]  ya_q, yb_q, walk_y_q, tgt_y_q;
  logic [MONTH_W-1:0] ma_q, mb_q, walk_m_q, tgt_m_q;
  logic [DAY_W-1:0]   da_q, db_q, walk_d_q, tgt_d_q;
  logic [COUNT_W-1:0] count_q;

  logic [YEAR_W-1:0]  next_y;
  logic [MONTH_W-1:0] next_m;
  logic [DAY_W-1:0]   next_d;
  logic [DAY_W-1:0]   len_a, len_b, len_walk;
  logic [COUNT_W-1:0] count_inc;
  logic               a_lt_b;

  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    r = m;
    if (m < MONTH_JAN) r = MONTH_JAN;
    if (m > MONTH_DEC) r = MONTH_DEC;
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0] d,
                                                 input logic [DAY_W-1:0] len);
    logic [DAY_W-1:0] r;
    r = d;
    if (d < DAY_FIRST) r = DAY_FIRST;
    if (d > len) r = len;
    return r;
  endfunction

  assign len_a    = month_days(ma_q, is_leap(ya_q));
  assign len_b    = month_days(mb_q, is_leap(yb_q));
  assign len_walk = month_days(walk_m_q, is_leap(walk_y_q));

  // Dates are corrected before ordering, so a plain lexicographic compare works.
  assign a_lt_b = (ya_q < yb_q) ||
                  ((ya_q == yb_q) && ((ma_q < mb_q) || ((ma_q == mb_q) && (da_q < db_q))));

  always_comb begin
    next_y = walk_y_q;
    next_m = walk_m_q;
    next_d = walk_d_q + DAY_W'(1);
    if (walk_d_q >= len_walk) begin
      next_d = DAY_FIRST;
      if (walk_m_q == MONTH_DEC) begin
        next_m = MONTH_JAN;
        next_y = walk_y_q + YEAR_W'(1);
      end else begin
        next_m = walk_m_q + MONTH_W'(1);
      end
    end
  end

  assign count_inc = count_q + COUNT_W'(1);

  assign status_o.equal = (ya_q == yb_q) && (ma_q == mb_q) && (da_q == db_q);
  assign status_o.last  = ((next_y == tgt_y_q) && (next_m == tgt_m_q) && (next_d == tgt_d_q))
                          || (count_inc == COUNT_MAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ya_q <= year_a_i;
      ma_q <= clamp_month(month_a_i);
      da_q <= day_a_i;
      yb_q <= year_b_i;
      mb_q <= clamp_month(month_b_i);
      db_q <= day_b_i;
    end
    if (cmd_i.fix) begin
      da_q <= clamp_day(da_q, len_a);
      db_q <= clamp_day(db_q, len_b);
    end
    if (cmd_i.order) begin
      if (a_lt_b) begin
        walk_y_q <= ya_q; walk_m_q <= ma_q; walk_d_q <= da_q;
        tgt_y_q  <= yb_q; tgt_m_q  <= mb_q; tgt_d_q  <= db_q;
      end else begin
        walk_y_q <= yb_q; walk_m_q <= mb_q; walk_d_q <= db_q;
        tgt_y_q  <= ya_q; tgt_m_q  <= ma_q; tgt_d_q  <= da_q;
      end
      // Inclusive count: both end days are counted.
      count_q <= status_o.equal ? '0 : COUNT_W'(1);
    end
    if (cmd_i.step) begin
      walk_y_q <= next_y;
      walk_m_q <= next_m;
      walk_d_q <= next_d;
      count_q  <= count_inc;
    end
  end

  assign day_count_o = count_q;

endmodule

// ===== rtl/core/date_difference_counter_core.sv =====
// Top level of the date difference counter: controller plus datapath.
//
// Usage: drive two Gregorian dates on year_a_i/month_a_i/day_a_i and
// year_b_i/month_b_i/day_b_i and raise start_i. The beat is taken at the
// rising edge where start_i is high and busy_o is low; the inputs need
// not be held after that edge. Months outside 1 to 12 and days outside
// the month are clamped to the nearest real date before the compare.
// The block then walks the earlier date forward one calendar day per
// clock, so the walk loop of the datapath sets the latency. The result
// beat on day_count_o is marked by done_o for exactly one cycle. For
// equal dates the walk is skipped and done_o carries zero. Otherwise
// it carries D + 1, where D is the distance in days. The walk stops
// early once the count saturates at its 22-bit maximum. busy_o is low
// during the done_o cycle, so the next beat can be taken then. The
// receiver cannot stall the block; it must take the result in the
// done_o cycle. Reset returns the controller to idle with no result pending.
module date_difference_counter_core
  import ddc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [YEAR_W-1:0]  year_a_i,
  input  logic [MONTH_W-1:0] month_a_i,
  input  logic [DAY_W-1:0]   day_a_i,
  input  logic [YEAR_W-1:0]  year_b_i,
  input  logic [MONTH_W-1:0] month_b_i,
  input  logic [DAY_W-1:0]   day_b_i,
  output logic               done_o,
  output logic [COUNT_W-1:0] day_count_o
);

  // Commands go from the controller to the datapath; status comes back.
  ddc_cmd_t    cmd;
  ddc_status_t status;

  ddc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // The datapath holds the corrected dates, the walking date and the count.
  ddc_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .year_a_i    (year_a_i),
    .month_a_i   (month_a_i),
    .day_a_i     (day_a_i),
    .year_b_i    (year_b_i),
    .month_b_i   (month_b_i),
    .day_b_i     (day_b_i),
    .status_o    (status),
    .day_count_o (day_count_o)
  );

endmodule

// ===== rtl/core/ddc_checker.sv =====
// Port-level assertions for the date difference counter, bound to its top level.
module ddc_checker
  import ddc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [COUNT_W-1:0] day_count_o
);

  // An accepted beat makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o did not rise after an accepted beat");

  // The result beat marks the end of the work, so the block is idle then.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("busy_o high during a result beat");

  // No result can arrive while the controller is still in its fix or order state after an accepted beat.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !done_o ##1 !done_o)
    else $error("result beat arrived too early");

  // The count is inclusive, so a result is zero or at least two.
  a_no_count_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (day_count_o != COUNT_W'(1)))
    else $error("day_count_o of one is impossible");

endmodule

bind date_difference_counter_core ddc_checker u_ddc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .day_count_o (day_count_o)
);
